@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with active-low rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define GCLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define GCLP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/gclp_pkg.sv @@
// ----------------------------------------------------------------------------
// gclp_pkg
// widths, character codes, status codes and parse types of the g-code parser
// ----------------------------------------------------------------------------
package gclp_pkg;

    localparam int LINE_BUFFER = 256;
    localparam int FRAC_DIGITS = 3;

    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int GCODE_W  = 16;
    localparam int VALUE_W  = 32;

    localparam int CNT_W  = $clog2(LINE_BUFFER);
    localparam int FC_W   = (FRAC_DIGITS < 2) ? 1 : $clog2(FRAC_DIGITS + 1);
    localparam int ACC_W  = 32;
    localparam int SUM_W  = 36;

    function automatic int pow10(input int n);
        int v;
        v = 1;
        for (int i = 0; i < n; i++)
        begin
            v = v * 10;
        end
        return v;
    endfunction

    localparam int INT_SCALE = pow10(FRAC_DIGITS);

    localparam logic [ACC_W-1:0] G_CAP = ACC_W'(32768);
    localparam logic [ACC_W-1:0] F_CAP = ACC_W'(64'h8000_0000);
    localparam logic [GCODE_W-1:0] G_MAX = 16'h7fff;
    localparam logic [VALUE_W-1:0] F_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] FEED_RESET = 32'd1000000;
    localparam logic [GCODE_W-1:0] G_NONE = 16'hffff;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3b;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h58;
    localparam logic [CHAR_W-1:0] CH_Y     = 8'h59;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    localparam logic [GCODE_W-1:0] G_RAPID  = 16'd0;
    localparam logic [GCODE_W-1:0] G_LINEAR = 16'd1;
    localparam logic [GCODE_W-1:0] G_HOME   = 16'd28;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BLANK  = 2'd1,
        ST_NO_G   = 2'd2,
        ST_UNSUP  = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SKIP   = 6'b000010,
        PH_SIGNED = 6'b000100,
        PH_POINT  = 6'b001000,
        PH_INT    = 6'b010000,
        PH_FRAC   = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        W_NONE = 3'd0,
        W_G    = 3'd1,
        W_X    = 3'd2,
        W_Y    = 3'd3,
        W_F    = 3'd4
    } word_t;

endpackage

@@ rtl/gclp_if.sv @@
// ----------------------------------------------------------------------------
// gclp channel interfaces
// valid/ready channels for character items and line result items
// ----------------------------------------------------------------------------
interface gclp_char_if
    import gclp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_line;

    modport source (output valid, output char_code, output end_of_line, input ready);
    modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface gclp_result_if
    import gclp_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [GCODE_W-1:0]  g_code;
    logic signed [VALUE_W-1:0]  x_pos;
    logic signed [VALUE_W-1:0]  y_pos;
    logic                       has_x;
    logic                       has_y;
    logic signed [VALUE_W-1:0]  feed;

    modport source (output valid, output status, output g_code, output x_pos, output y_pos,
                    output has_x, output has_y, output feed, input ready);
    modport sink   (input valid, input status, input g_code, input x_pos, input y_pos,
                    input has_x, input has_y, input feed, output ready);
endinterface

@@ rtl/gcode_line_word_parser.sv @@
// an end-of-line item passes the input register; its line's result then loads the result register
// throughput: one character item per cycle, set by the single parse step between
// the input register and the result register
// back-pressure on results holds only an end-of-line item; the items behind it wait
// reset: asynchronous, active low; clears line state, default feed returns to 1000000
// ----------------------------------------------------------------------------
// gcode_line_word_parser
// parses g, x, y and f words of a g-code line, one character item a cycle,
// and gives one result item per line
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcode_line_word_parser
    import gclp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    gclp_char_if.sink           char_in,
    gclp_result_if.source       result_out,
    input  logic                default_feed_we,
    input  logic [VALUE_W-1:0]  default_feed_wdata
);

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic               ignore;
        logic               seen;
        word_t              word;
        phase_t             phase;
        logic               neg;
        logic [ACC_W-1:0]   acc;
        logic [FC_W-1:0]    fc;
        logic [GCODE_W-1:0] g;
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] y;
        logic [VALUE_W-1:0] f;
        logic               x_seen;
        logic               y_seen;
        logic               f_seen;
    } line_t;

    localparam line_t LINE_RESET = '{
        count:  '0,
        ignore: 1'b0,
        seen:   1'b0,
        word:   W_NONE,
        phase:  PH_IDLE,
        neg:    1'b0,
        acc:    '0,
        fc:     '0,
        g:      G_NONE,
        x:      '0,
        y:      '0,
        f:      '0,
        x_seen: 1'b0,
        y_seen: 1'b0,
        f_seen: 1'b0
    };

    function automatic logic [SUM_W-1:0] frac_weight(input logic [FC_W-1:0] fc);
        logic [SUM_W-1:0] w;
        w = '0;
        for (int i = 0; i < FRAC_DIGITS; i++)
        begin
            if (fc == FC_W'(i))
            begin
                w = SUM_W'(pow10(FRAC_DIGITS - 1 - i));
            end
        end
        return w;
    endfunction

    function automatic line_t add_int(input line_t ln, input logic [3:0] d);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] cap;
        if (ln.word == W_G)
        begin
            sum = (SUM_W'(ln.acc) << 3) + (SUM_W'(ln.acc) << 1) + SUM_W'(d);
            cap = SUM_W'(G_CAP);
        end
        else
        begin
            sum = (SUM_W'(ln.acc) << 3) + (SUM_W'(ln.acc) << 1)
                + SUM_W'(d) * SUM_W'(INT_SCALE);
            cap = SUM_W'(F_CAP);
        end
        ln.acc = (sum > cap) ? cap[ACC_W-1:0] : sum[ACC_W-1:0];
        return ln;
    endfunction

    function automatic line_t add_frac(input line_t ln, input logic [3:0] d);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(ln.acc) + SUM_W'(d) * frac_weight(ln.fc);
        if (SUM_W'(ln.fc) < SUM_W'(FRAC_DIGITS))
        begin
            ln.acc = (sum > SUM_W'(F_CAP)) ? F_CAP : sum[ACC_W-1:0];
            ln.fc  = ln.fc + 1'b1;
        end
        return ln;
    endfunction

    function automatic line_t commit(input line_t ln);
        logic [VALUE_W-1:0] v;
        v = ln.neg ? (VALUE_W'(0) - ln.acc)
                   : ((ln.acc > F_MAX) ? F_MAX : ln.acc);
        if (ln.phase == PH_INT || ln.phase == PH_FRAC)
        begin
            case (ln.word)
                W_G:
                begin
                    if (ln.neg)
                        ln.g = GCODE_W'(0) - ln.acc[GCODE_W-1:0];
                    else
                        ln.g = (ln.acc > ACC_W'(G_MAX)) ? G_MAX : ln.acc[GCODE_W-1:0];
                end
                W_X:
                begin
                    ln.x      = v;
                    ln.x_seen = 1'b1;
                end
                W_Y:
                begin
                    ln.y      = v;
                    ln.y_seen = 1'b1;
                end
                W_F:
                begin
                    ln.f      = v;
                    ln.f_seen = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        ln.phase = PH_IDLE;
        ln.word  = W_NONE;
        return ln;
    endfunction

    function automatic line_t take_char(input line_t ln, input logic [CHAR_W-1:0] c);
        logic       blank;
        logic       digit;
        logic       flt;
        logic       cont;
        logic [3:0] d;
        blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        digit = (c >= CH_0) && (c <= CH_9);
        flt   = (ln.word != W_G);
        d     = c[3:0];
        cont  = 1'b0;
        if (!blank)
            ln.seen = 1'b1;
        if (ln.phase != PH_IDLE)
        begin
            unique case (ln.phase) inside
                PH_SKIP, PH_SIGNED:
                begin
                    if (ln.phase == PH_SKIP && blank)
                    begin
                        cont = 1'b1;
                    end
                    else if (ln.phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS))
                    begin
                        ln.neg   = (c == CH_MINUS);
                        ln.phase = PH_SIGNED;
                        cont     = 1'b1;
                    end
                    else if (digit)
                    begin
                        ln       = add_int(ln, d);
                        ln.phase = PH_INT;
                        cont     = 1'b1;
                    end
                    else if (c == CH_POINT && flt)
                    begin
                        ln.phase = PH_POINT;
                        cont     = 1'b1;
                    end
                end
                PH_INT:
                begin
                    if (digit)
                    begin
                        ln   = add_int(ln, d);
                        cont = 1'b1;
                    end
                    else if (c == CH_POINT && flt)
                    begin
                        ln.phase = PH_FRAC;
                        cont     = 1'b1;
                    end
                end
                PH_POINT, PH_FRAC:
                begin
                    if (digit)
                    begin
                        ln       = add_frac(ln, d);
                        ln.phase = PH_FRAC;
                        cont     = 1'b1;
                    end
                end
                default:
                begin
                    cont = 1'b0;
                end
            endcase
            if (!cont)
                ln = commit(ln);
        end
        if (!cont && (c == CH_G || c == CH_X || c == CH_Y || c == CH_F))
        begin
            ln.word  = (c == CH_G) ? W_G : (c == CH_X) ? W_X : (c == CH_Y) ? W_Y : W_F;
            ln.phase = PH_SKIP;
            ln.neg   = 1'b0;
            ln.acc   = '0;
            ln.fc    = '0;
        end
        return ln;
    endfunction

    // input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_eol_reg;
    logic              s1_adv;
    logic              s1_hold;
    logic              in_take;

    // line state and config
    line_t              line_reg;
    line_t              line_next;
    line_t              step_st;
    line_t              fin_st;
    logic [VALUE_W-1:0] default_feed_reg;
    logic [CHAR_W-1:0]  fold_char;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_load;
    status_t            out_status_reg;
    status_t            out_status_next;
    logic [GCODE_W-1:0] out_g_reg;
    logic [VALUE_W-1:0] out_x_reg;
    logic [VALUE_W-1:0] out_y_reg;
    logic               out_hx_reg;
    logic               out_hy_reg;
    logic [VALUE_W-1:0] out_feed_reg;
    logic               out_g_ok;

    assign s1_adv   = s1_valid_reg && (!s1_eol_reg || !out_valid_reg || result_out.ready);
    assign s1_hold  = s1_valid_reg && !s1_adv;
    assign in_take  = char_in.valid && char_in.ready;
    assign out_load = s1_adv && s1_eol_reg;
    assign out_g_ok = (out_g_reg == G_RAPID) || (out_g_reg == G_LINEAR) || (out_g_reg == G_HOME);

    assign char_in.ready  = !s1_valid_reg || s1_adv;
    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = out_load || (out_valid_reg && !result_out.ready);

    always_comb
    begin
        fold_char = s1_char_reg;
        if (s1_char_reg >= CH_LA && s1_char_reg <= CH_LZ)
            fold_char = s1_char_reg - CASE_OFS;
        step_st = line_reg;
        if (!line_reg.ignore)
        begin
            if (s1_char_reg == CH_SEMI || s1_char_reg == CH_NUL ||
                line_reg.count >= CNT_W'(LINE_BUFFER - 1))
            begin
                step_st.ignore = 1'b1;
            end
            else
            begin
                step_st.count = line_reg.count + 1'b1;
                step_st       = take_char(step_st, fold_char);
            end
        end
        fin_st    = commit(step_st);
        line_next = s1_eol_reg ? LINE_RESET : step_st;
    end

    always_comb
    begin
        if (!fin_st.seen)
            out_status_next = ST_BLANK;
        else if (fin_st.g[GCODE_W-1])
            out_status_next = ST_NO_G;
        else if (fin_st.g == G_RAPID || fin_st.g == G_LINEAR || fin_st.g == G_HOME)
            out_status_next = ST_OK;
        else
            out_status_next = ST_UNSUP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            line_reg         <= LINE_RESET;
            default_feed_reg <= FEED_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
                line_reg <= line_next;
            if (default_feed_we)
                default_feed_reg <= default_feed_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= char_in.char_code;
            s1_eol_reg  <= char_in.end_of_line;
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_g_reg      <= fin_st.g;
            out_x_reg      <= fin_st.x;
            out_y_reg      <= fin_st.y;
            out_hx_reg     <= fin_st.x_seen;
            out_hy_reg     <= fin_st.y_seen;
            out_feed_reg   <= fin_st.f_seen ? fin_st.f : default_feed_reg;
        end
    end

    assign result_out.valid  = out_valid_reg;
    assign result_out.status = out_status_reg;
    assign result_out.g_code = out_g_reg;
    assign result_out.x_pos  = out_x_reg;
    assign result_out.y_pos  = out_y_reg;
    assign result_out.has_x  = out_hx_reg;
    assign result_out.has_y  = out_hy_reg;
    assign result_out.feed   = out_feed_reg;

    `GCLP_ASSERT(a_load_shows, out_load |=> out_valid_reg, "result load not shown")
    `GCLP_ASSERT(a_line_cleared, out_load |=> (line_reg == LINE_RESET), "line state not cleared")
    `GCLP_ASSERT(a_s1_hold, s1_hold |=> (s1_valid_reg && $stable(s1_char_reg)), "held item lost")
    `GCLP_ASSERT_IMP(a_ok_code, out_valid_reg && out_status_reg == ST_OK, out_g_ok, "bad ok code")

endmodule

@@ tb/gclp_line_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclp_line_checker
// watches the character and result channels of the g-code line parser,
// rebuilds each line's words from the accepted character items and compares
// every result item field by field with the oldest predicted line
// ----------------------------------------------------------------------------
module gclp_line_checker
    import gclp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    gclp_char_if               char_mon,
    gclp_result_if             result_mon,
    input  logic               default_feed_we,
    input  logic [VALUE_W-1:0] default_feed_wdata,
    output int unsigned        mismatch_count,
    output int unsigned        lines_pending
);

    localparam logic [63:0] G_SAT_MAG  = 64'd32768;
    localparam logic [63:0] V_SAT_MAG  = 64'h8000_0000;
    localparam int          MAX_PRINTS = 50;

    typedef struct packed {
        status_t                   status;
        logic signed [GCODE_W-1:0] g_code;
        logic signed [VALUE_W-1:0] x_pos;
        logic signed [VALUE_W-1:0] y_pos;
        logic                      has_x;
        logic                      has_y;
        logic signed [VALUE_W-1:0] feed;
    } line_result_t;

    logic [VALUE_W-1:0] feed_default;
    int unsigned        line_chars;
    logic               skip_rest;
    logic               text_seen;
    word_t              cur_word;
    phase_t             cur_phase;
    logic               num_neg;
    logic [63:0]        num_mag;
    logic [63:0]        frac_weight;
    int                 g_val;
    logic [VALUE_W-1:0] x_val;
    logic [VALUE_W-1:0] y_val;
    logic [VALUE_W-1:0] f_val;
    logic               x_got;
    logic               y_got;
    logic               f_got;
    line_result_t       expected_lines[$];
    int unsigned        lines_checked;

    function automatic logic blank_char(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_line();
        line_chars  = 0;
        skip_rest   = 1'b0;
        text_seen   = 1'b0;
        cur_word    = W_NONE;
        cur_phase   = PH_IDLE;
        num_neg     = 1'b0;
        num_mag     = '0;
        frac_weight = '0;
        g_val       = -1;
        x_val       = '0;
        y_val       = '0;
        f_val       = '0;
        x_got       = 1'b0;
        y_got       = 1'b0;
        f_got       = 1'b0;
    endfunction

    // a word only changes when its number holds at least one digit
    function automatic void commit_word();
        logic [VALUE_W-1:0] v;
        if (cur_phase == PH_INT || cur_phase == PH_FRAC)
        begin
            if (cur_word == W_G)
            begin
                if (num_neg)
                    g_val = -int'(num_mag);
                else
                    g_val = (num_mag > 64'(G_MAX)) ? int'(G_MAX) : int'(num_mag);
            end
            else
            begin
                if (num_neg)
                    v = VALUE_W'(0) - num_mag[VALUE_W-1:0];
                else
                    v = (num_mag > 64'(F_MAX)) ? F_MAX : num_mag[VALUE_W-1:0];
                case (cur_word)
                    W_X:
                    begin
                        x_val = v;
                        x_got = 1'b1;
                    end
                    W_Y:
                    begin
                        y_val = v;
                        y_got = 1'b1;
                    end
                    W_F:
                    begin
                        f_val = v;
                        f_got = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        cur_phase = PH_IDLE;
        cur_word  = W_NONE;
    endfunction

    function automatic logic predict_char(input logic [CHAR_W-1:0] raw, input logic eol,
                                          output line_result_t res);
        logic [CHAR_W-1:0] c;
        logic [63:0]       d;
        logic              consumed;
        res = '0;
        if (!skip_rest)
        begin
            if (raw == CH_SEMI || raw == CH_NUL || line_chars >= LINE_BUFFER - 1)
                skip_rest = 1'b1;
            else
            begin
                line_chars++;
                c = (raw >= CH_LA && raw <= CH_LZ) ? raw - CASE_OFS : raw;
                d = 64'(c - CH_0);
                consumed = 1'b0;
                if (!blank_char(c))
                    text_seen = 1'b1;
                if (cur_phase != PH_IDLE)
                begin
                    if (cur_phase == PH_SKIP && blank_char(c))
                        consumed = 1'b1;
                    else if (cur_phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS))
                    begin
                        num_neg   = (c == CH_MINUS);
                        cur_phase = PH_SIGNED;
                        consumed  = 1'b1;
                    end
                    else if (c >= CH_0 && c <= CH_9)
                    begin
                        consumed = 1'b1;
                        if (cur_phase == PH_POINT || cur_phase == PH_FRAC)
                        begin
                            // digits past the kept fraction have zero weight
                            num_mag     = num_mag + d * frac_weight;
                            frac_weight = frac_weight / 10;
                            if (num_mag > V_SAT_MAG)
                                num_mag = V_SAT_MAG;
                            cur_phase = PH_FRAC;
                        end
                        else if (cur_word == W_G)
                        begin
                            num_mag = num_mag * 10 + d;
                            if (num_mag > G_SAT_MAG)
                                num_mag = G_SAT_MAG;
                            cur_phase = PH_INT;
                        end
                        else
                        begin
                            num_mag = num_mag * 10 + d * INT_SCALE;
                            if (num_mag > V_SAT_MAG)
                                num_mag = V_SAT_MAG;
                            cur_phase = PH_INT;
                        end
                    end
                    else if (c == CH_POINT && cur_word != W_G && cur_phase != PH_POINT
                             && cur_phase != PH_FRAC)
                    begin
                        consumed  = 1'b1;
                        cur_phase = (cur_phase == PH_INT) ? PH_FRAC : PH_POINT;
                    end
                    if (!consumed)
                        commit_word();
                end
                if (!consumed)
                begin
                    case (c)
                        CH_G:    cur_word = W_G;
                        CH_X:    cur_word = W_X;
                        CH_Y:    cur_word = W_Y;
                        CH_F:    cur_word = W_F;
                        default: cur_word = W_NONE;
                    endcase
                    if (cur_word != W_NONE)
                    begin
                        cur_phase   = PH_SKIP;
                        num_neg     = 1'b0;
                        num_mag     = '0;
                        frac_weight = 64'(INT_SCALE / 10);
                    end
                end
            end
        end
        if (!eol)
            return 1'b0;
        commit_word();
        if (!text_seen)
            res.status = ST_BLANK;
        else if (g_val < 0)
            res.status = ST_NO_G;
        else if (g_val == int'(G_RAPID) || g_val == int'(G_LINEAR) || g_val == int'(G_HOME))
            res.status = ST_OK;
        else
            res.status = ST_UNSUP;
        res.g_code = g_val[GCODE_W-1:0];
        res.x_pos  = x_val;
        res.y_pos  = y_val;
        res.has_x  = x_got;
        res.has_y  = y_got;
        res.feed   = f_got ? f_val : feed_default;
        clear_line();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < MAX_PRINTS)
            $display("line %0d: %s got %0d expected %0d", lines_checked, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t res;
        if (!rst_n)
        begin
            feed_default = FEED_RESET;
            clear_line();
            expected_lines.delete();
            mismatch_count = 0;
            lines_checked  = 0;
            lines_pending <= 0;
        end
        else
        begin
            if (default_feed_we)
                feed_default = default_feed_wdata;
            if (char_mon.valid && char_mon.ready)
            begin
                if (predict_char(char_mon.char_code, char_mon.end_of_line, res))
                    expected_lines.push_back(res);
            end
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_lines.size() == 0)
                    report_mismatch("result with no line pending, status", result_mon.status, 0);
                else
                begin
                    res = expected_lines.pop_front();
                    if (result_mon.status !== res.status)
                        report_mismatch("status", result_mon.status, res.status);
                    if (result_mon.g_code !== res.g_code)
                        report_mismatch("g_code", result_mon.g_code, res.g_code);
                    if (result_mon.x_pos !== res.x_pos)
                        report_mismatch("x_pos", result_mon.x_pos, res.x_pos);
                    if (result_mon.y_pos !== res.y_pos)
                        report_mismatch("y_pos", result_mon.y_pos, res.y_pos);
                    if (result_mon.has_x !== res.has_x)
                        report_mismatch("has_x", result_mon.has_x, res.has_x);
                    if (result_mon.has_y !== res.has_y)
                        report_mismatch("has_y", result_mon.has_y, res.has_y);
                    if (result_mon.feed !== res.feed)
                        report_mismatch("feed", result_mon.feed, res.feed);
                end
                lines_checked++;
            end
            lines_pending <= expected_lines.size();
        end
    end

endmodule

@@ tb/tb_gcode_line_word_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gcode_line_word_parser
// sends directed and random g-code lines as character items in bursts, stalls
// the result side, steps the default feed through its extremes between lines
// and takes the verdict from the line checker
// ----------------------------------------------------------------------------
module tb_gcode_line_word_parser;
    import gclp_pkg::*;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;

    logic               clk;
    logic               rst_n;
    logic               default_feed_we;
    logic [VALUE_W-1:0] default_feed_wdata;
    int unsigned        mismatch_count;
    int unsigned        lines_pending;
    int unsigned        cycle_count = 0;
    int unsigned        items_sent  = 0;
    int                 burst_left  = 0;
    int                 stall_pct   = 0;
    int                 pattern_left = 0;
    byte unsigned       line_buf[$];

    gclp_char_if   char_if();
    gclp_result_if result_if();

    gcode_line_word_parser i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .char_in            (char_if),
        .result_out         (result_if),
        .default_feed_we    (default_feed_we),
        .default_feed_wdata (default_feed_wdata)
    );

    gclp_line_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .char_mon           (char_if),
        .result_mon         (result_if),
        .default_feed_we    (default_feed_we),
        .default_feed_wdata (default_feed_wdata),
        .mismatch_count     (mismatch_count),
        .lines_pending      (lines_pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // result side: ready stalls at a stall rate that is redrawn at random
    always @(posedge clk)
    begin
        if (pattern_left == 0)
        begin
            case ($urandom_range(0, 4)) inside
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                3:       stall_pct = 70;
                default: stall_pct = 95;
            endcase
            pattern_left = $urandom_range(20, 120);
        end
        pattern_left--;
        result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_item(input byte unsigned c, input logic eol);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                char_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        char_if.valid       <= 1'b1;
        char_if.char_code   <= c;
        char_if.end_of_line <= eol;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_line();
        if (line_buf.size() == 0)
            line_buf.push_back(CH_SPACE);
        for (int i = 0; i < line_buf.size(); i++)
            send_item(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic text_line(input string s);
        add_text(s);
        send_line();
    endtask

    task automatic add_digits(input int n);
        repeat (n)
            line_buf.push_back(CHAR_W'(CH_0 + $urandom_range(0, 9)));
    endtask

    task automatic add_blanks(input int n);
        int k;
        repeat (n)
        begin
            k = $urandom_range(0, 5);
            line_buf.push_back(CHAR_W'((k == 5) ? CH_SPACE : CH_TAB + k));
        end
    endtask

    // wait until every line has its result and the pipeline has drained
    task automatic settle();
        char_if.valid <= 1'b0;
        @(posedge clk);
        while (lines_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_default_feed(input logic [VALUE_W-1:0] v);
        settle();
        default_feed_we    <= 1'b1;
        default_feed_wdata <= v;
        @(posedge clk);
        default_feed_we    <= 1'b0;
    endtask

    task automatic add_word();
        int           pick;
        int           r;
        byte unsigned letter;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 2) == 0)
            add_blanks($urandom_range(1, 2));
        if (pick < 85)
        begin
            case ($urandom_range(0, 3))
                0:       letter = CH_G;
                1:       letter = CH_X;
                2:       letter = CH_Y;
                default: letter = CH_F;
            endcase
            if ($urandom_range(0, 4) == 0)
                letter = letter + CASE_OFS;
            line_buf.push_back(letter);
            if ($urandom_range(0, 5) == 0)
                add_blanks($urandom_range(1, 2));
            r = $urandom_range(0, 9);
            if (r == 0)
                line_buf.push_back(CH_PLUS);
            else if (r < 3)
                line_buf.push_back(CH_MINUS);
            if (letter == CH_G || letter == CH_G + CASE_OFS)
            begin
                r = $urandom_range(0, 9);
                if (r < 2)
                    add_text("0");
                else if (r < 4)
                    add_text("1");
                else if (r < 6)
                    add_text("28");
                else if (r < 8)
                    add_text($sformatf("%0d", $urandom_range(0, 99)));
                else if (r < 9)
                    add_text($sformatf("%0d", $urandom_range(0, 99999)));
                else
                    add_digits($urandom_range(0, 12));
                if ($urandom_range(0, 9) == 0)
                begin
                    line_buf.push_back(CH_POINT);
                    add_digits(1);
                end
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    r = 0;
                else if (r < 8)
                    r = $urandom_range(1, 4);
                else if (r < 9)
                    r = $urandom_range(5, 7);
                else
                    r = $urandom_range(8, 12);
                add_digits(r);
                if ($urandom_range(0, 2) != 0)
                begin
                    line_buf.push_back(CH_POINT);
                    add_digits($urandom_range(0, 5));
                end
            end
        end
        else if (pick < 93)
        begin
            line_buf.push_back(CHAR_W'(CH_LA - CASE_OFS + $urandom_range(0, 25)));
            add_digits($urandom_range(0, 3));
        end
        else
            line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
    endtask

    task automatic build_random_line();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 6)
            repeat ($urandom_range(1, 24))
                line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
        else if (kind < 8)
        begin
            add_text("G1 X");
            add_digits($urandom_range(240, 290));
            add_word();
        end
        else
        begin
            repeat ($urandom_range(1, 5))
                add_word();
            case ($urandom_range(0, 19)) inside
                0, 1:
                begin
                    line_buf.push_back(CH_SEMI);
                    add_word();
                end
                2:
                begin
                    line_buf.push_back(CH_NUL);
                    add_word();
                end
                3: add_blanks($urandom_range(1, 3));
                4:
                begin
                    line_buf.delete();
                    add_blanks($urandom_range(1, 4));
                end
                default: ;
            endcase
        end
    endtask

    task automatic run_directed();
        text_line("G0 X1.5 Y-2.25 F300");
        text_line("g1x10y20f1500.5");
        text_line("G28");
        text_line("G2 X1");
        text_line("X5 Y-7.125");
        for (int k = 0; k < 5; k++)
            line_buf.push_back(CHAR_W'(CH_TAB + k));
        line_buf.push_back(CH_SPACE);
        send_line();
        text_line(";G1 X5");
        text_line("G1 X2;X9");
        add_text("G1 X3");
        line_buf.push_back(CH_NUL);
        add_text("X9");
        send_line();
        line_buf.push_back(CH_NUL);
        send_line();
        text_line("G-1");
        text_line("G-0 X-0");
        text_line("G99999 X99999999 Y-99999999");
        text_line("G-99999");
        text_line("G1 X2147483.647 Y-2147483.648");
        text_line("G1 X2147483.648 F.12345");
        text_line("G1 X. Y- F+");
        text_line("G 1 X \t 4 Y+.5");
        text_line("G1 X1 X2 Y5 Y.");
        text_line("G1.5 X7");
        add_text("G1 X");
        repeat (300)
            line_buf.push_back(CH_9);
        add_text("Y5");
        send_line();
        line_buf.push_back(8'hff);
        line_buf.push_back(8'h80);
        line_buf.push_back(8'h7f);
        add_text("G0");
        send_line();
        text_line("G1X5g0");
        text_line("GXY");
        text_line("G28 Z9 M3 F-50");
    endtask

    initial
    begin
        rst_n               = 1'b0;
        char_if.valid       = 1'b0;
        char_if.char_code   = '0;
        char_if.end_of_line = 1'b0;
        result_if.ready     = 1'b0;
        default_feed_we     = 1'b0;
        default_feed_wdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_default_feed(32'h8000_0000);
                1:       write_default_feed(32'h7fff_ffff);
                2:       write_default_feed('0);
                3:       write_default_feed($urandom);
                default: write_default_feed(32'hffff_ffff);
            endcase
            items_sent = 0;
            while (items_sent < RANDOM_ITEMS / PHASES)
            begin
                build_random_line();
                send_line();
            end
        end
        settle();
        if (mismatch_count == 0 && lines_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ gcode_line_word_parser.f @@
+incdir+rtl
rtl/gclp_pkg.sv
rtl/gclp_if.sv
rtl/gcode_line_word_parser.sv
tb/gclp_line_checker.sv
tb/tb_gcode_line_word_parser.sv
